[hdl/ps2mct_pkg.sv]
package ps2mct_pkg;

    localparam int SIZE_W = 13;
    localparam int POS_W  = 12;
    localparam int SUM_W  = 14;    // signed: pos +/- 9-bit motion

    localparam logic [SIZE_W-1:0] SIZE_MIN   = 13'd16;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 13'd4096;
    localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd1024;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd768;
    localparam logic [POS_W-1:0]  POS_MAX    = 12'd4095;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    // packet byte position
    localparam logic [1:0] IDX_HEADER = 2'd0;
    localparam logic [1:0] IDX_X      = 2'd1;
    localparam logic [1:0] IDX_Y      = 2'd2;

    // header bits
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;

    localparam int TDATA_OUT_W = 32;

    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v);
        if (v < SIZE_MIN) begin
            return SIZE_MIN;
        end else if (v > SIZE_MAX) begin
            return SIZE_MAX;
        end
        return v;
    endfunction

    // clamp limit: size - margin, capped to the 12-bit position range
    function automatic logic [POS_W-1:0] pos_limit(input logic [SIZE_W-1:0] size,
                                                   input logic [3:0] margin);
        logic [SIZE_W-1:0] d;
        d = size - {{(SIZE_W-4){1'b0}}, margin};
        if (d > {1'b0, POS_MAX}) begin
            return POS_MAX;
        end
        return d[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] v,
                                                   input logic [POS_W-1:0] lim);
        if (v < 0) begin
            return '0;
        end else if (v >= $signed({2'b00, lim})) begin
            return lim;
        end
        return v[POS_W-1:0];
    endfunction

endpackage

[hdl/ps2_mouse_cursor_tracker.sv]
// Path: the Y-motion byte passes the input reg and then the result reg, which drives m_tvalid;
// the result waits in the result reg until m_tready takes it.
// Throughput: one byte per cycle and one result per three bytes while m_tready keeps up;
// a held result stalls the input stage only when the Y byte would overwrite it.
// Reset (aresetn low, synchronous): screen 1024x768, cursor centered at 512,384,
// packet position back to the header byte, both stages empty.
module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
#(
    parameter int CURSOR_MARGIN = 8    // 0..15
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,      // 0: screen_width, 1: screen_height
    input  logic [12:0] cfg_wdata,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] data_byte
    // cursor results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata  // [11:0] cursor_x, [23:12] cursor_y,
                                            // [24] left_button, [25] right_button, rest 0
);

    localparam logic [3:0] MARGIN = 4'(CURSOR_MARGIN);

    // input stage
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;

    // packet and cursor state
    logic [1:0]        byte_index_reg;
    logic [7:0]        header_reg;
    logic [7:0]        x_motion_reg;
    logic [POS_W-1:0]  pos_x_reg, pos_y_reg;
    logic [POS_W-1:0]  pos_x_next, pos_y_next;
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [SIZE_W-1:0] cfg_size;

    // result stage
    logic              out_valid_reg;
    logic [25:0]       out_data_reg;

    logic              is_y_byte;
    logic              advance;
    logic [8:0]        x_motion9, y_motion9;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic [POS_W-1:0]  lim_x, lim_y;

    // the Y byte needs the result register free; header and X bytes never do
    assign is_y_byte = (byte_index_reg == IDX_Y);
    assign advance   = in_valid_reg && (!is_y_byte || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    // 9-bit two's-complement motion, sign from the header
    assign x_motion9 = {header_reg[HDR_X_SIGN], x_motion_reg};
    assign y_motion9 = {header_reg[HDR_Y_SIGN], in_byte_reg};

    assign sum_x = $signed({2'b00, pos_x_reg}) + $signed({{(SUM_W-9){x_motion9[8]}}, x_motion9});
    // rows grow downward: subtract Y
    assign sum_y = $signed({2'b00, pos_y_reg}) - $signed({{(SUM_W-9){y_motion9[8]}}, y_motion9});

    assign lim_x = pos_limit(width_reg, MARGIN);
    assign lim_y = pos_limit(height_reg, MARGIN);

    assign pos_x_next = clamp_pos(sum_x, lim_x);
    assign pos_y_next = clamp_pos(sum_y, lim_y);

    assign cfg_size = sat_size(cfg_wdata);

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // packet assembly, cursor update and size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= IDX_HEADER;
            width_reg      <= WIDTH_RST;
            height_reg     <= HEIGHT_RST;
            pos_x_reg      <= WIDTH_RST[SIZE_W-1:1];
            pos_y_reg      <= HEIGHT_RST[SIZE_W-1:1];
        end else begin
            if (cfg_wr_en && cfg_index == REG_WIDTH) begin
                // new size recenters, without clamping
                width_reg <= cfg_size;
                pos_x_reg <= cfg_size[SIZE_W-1:1];
                pos_y_reg <= height_reg[SIZE_W-1:1];
            end else if (cfg_wr_en && cfg_index == REG_HEIGHT) begin
                height_reg <= cfg_size;
                pos_x_reg  <= width_reg[SIZE_W-1:1];
                pos_y_reg  <= cfg_size[SIZE_W-1:1];
            end else if (advance) begin
                case (byte_index_reg)
                    IDX_X: begin
                        byte_index_reg <= IDX_Y;
                    end
                    IDX_Y: begin
                        byte_index_reg <= IDX_HEADER;
                        pos_x_reg      <= pos_x_next;
                        pos_y_reg      <= pos_y_next;
                    end
                    default: begin    // header byte, also a stray index of 3
                        byte_index_reg <= IDX_X;
                    end
                endcase
            end
        end
    end

    // packet payload bytes
    always_ff @(posedge aclk) begin
        if (advance && byte_index_reg == IDX_X) begin
            x_motion_reg <= in_byte_reg;
        end
        if (advance && byte_index_reg != IDX_X && byte_index_reg != IDX_Y) begin
            header_reg <= in_byte_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_y_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && is_y_byte) begin
            out_data_reg <= {header_reg[HDR_RIGHT], header_reg[HDR_LEFT],
                             pos_y_next, pos_x_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-26){1'b0}}, out_data_reg};

    // a new result appears only right after a Y byte was processed
    a_result_from_y: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance && is_y_byte))
        else $error("result raised without a completed packet");

    // a byte held in the input stage is not lost or changed
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte dropped");

    // a freshly written cursor never exceeds its clamp limit
    a_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_y_byte) |-> (pos_x_next <= lim_x && pos_y_next <= lim_y))
        else $error("cursor beyond clamp limit");

endmodule
